// ----- rtl/gzp_pkg.sv -----
// Package for the gzip header parser: phase and status codes, shared types
// and the helper that picks the next optional header section. No dependencies.
`default_nettype none

package gzp_pkg;

    localparam int unsigned LengthBitsDefault = 24;
    localparam int unsigned HeaderLengthWidth = 24;
    localparam int unsigned FixedBytes        = 10;

    localparam logic [7:0] MagicFirst    = 8'h1F;
    localparam logic [7:0] MagicSecond   = 8'h8B;
    localparam logic [7:0] MethodDeflate = 8'd8;
    localparam logic [7:0] ReservedMask  = 8'hE0;

    // Flag bits within the low five bits of the flag byte.
    localparam int unsigned FlagHcrcBit    = 1;
    localparam int unsigned FlagExtraBit   = 2;
    localparam int unsigned FlagNameBit    = 3;
    localparam int unsigned FlagCommentBit = 4;

    // Parse phases.
    localparam logic [3:0] PH_ID1      = 4'd0;
    localparam logic [3:0] PH_ID2      = 4'd1;
    localparam logic [3:0] PH_METHOD   = 4'd2;
    localparam logic [3:0] PH_FLAGS    = 4'd3;
    localparam logic [3:0] PH_FIXED    = 4'd4;
    localparam logic [3:0] PH_XLEN_LO  = 4'd5;
    localparam logic [3:0] PH_XLEN_HI  = 4'd6;
    localparam logic [3:0] PH_EXTRA    = 4'd7;
    localparam logic [3:0] PH_NAME     = 4'd8;
    localparam logic [3:0] PH_COMMENT  = 4'd9;
    localparam logic [3:0] PH_CRC_LO   = 4'd10;
    localparam logic [3:0] PH_CRC_HI   = 4'd11;
    localparam logic [3:0] PH_IDLE     = 4'd12;
    localparam logic [3:0] PH_COMPLETE = 4'd15;

    // Sections after which the next optional section is looked for.
    localparam logic [2:0] SEC_FIXED   = 3'd0;
    localparam logic [2:0] SEC_EXTRA   = 3'd1;
    localparam logic [2:0] SEC_NAME    = 3'd2;
    localparam logic [2:0] SEC_COMMENT = 3'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_BAD_METH  = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_step;

    typedef struct packed {
        logic                         valid;
        logic [2:0]                   status;
        logic [HeaderLengthWidth-1:0] header_length;
    } t_result;

    // First optional section still asked for by the flags after section sec.
    function automatic logic [3:0] next_section(input logic [4:0] flags,
                                                input logic [2:0] sec);
        logic [3:0] ph;
        ph = PH_COMPLETE;
        if (sec < SEC_COMMENT && flags[FlagHcrcBit]) begin
            ph = PH_CRC_LO;
        end
        if (sec == SEC_COMMENT && flags[FlagHcrcBit]) begin
            ph = PH_CRC_LO;
        end
        if (sec < SEC_COMMENT && flags[FlagCommentBit]) begin
            ph = PH_COMMENT;
        end
        if (sec < SEC_NAME && flags[FlagNameBit]) begin
            ph = PH_NAME;
        end
        if (sec < SEC_EXTRA && flags[FlagExtraBit]) begin
            ph = PH_XLEN_LO;
        end
        return ph;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gzp_byte_if.sv -----
// Byte channel into the gzip header parser: valid/ready handshake with one
// buffer byte and its last mark per word. Depends on nothing.
`default_nettype none

interface gzp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/gzp_result_if.sv -----
// Result channel out of the gzip header parser: valid/ready handshake with a
// status and a header length per word. Depends on nothing.
`default_nettype none

interface gzp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [23:0] header_length;

    modport source (output valid, output status, output header_length, input ready);
    modport sink   (input valid, input status, input header_length, output ready);
endinterface

`default_nettype wire

// ----- rtl/gzp_parse_core.sv -----
// Parse state of the gzip header parser and its one-byte update logic.
// Depends on gzp_pkg.
`default_nettype none

module gzp_parse_core #(
    parameter int unsigned LENGTH_BITS = gzp_pkg::LengthBitsDefault
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire gzp_pkg::t_step   i_step,
    output gzp_pkg::t_result      o_res
);
    import gzp_pkg::*;

    logic [3:0]             r_phase, n_phase;
    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic [4:0]             r_flags, n_flags;
    logic [15:0]            r_extra_rem, n_extra_rem;
    logic [7:0]             r_extra_lo, n_extra_lo;

    logic [LENGTH_BITS-1:0]                   w_count_inc;
    logic [15:0]                              w_rem_dec;
    logic [LENGTH_BITS+HeaderLengthWidth-1:0] w_count_ext;
    logic [3:0]                               w_next;
    logic                                     w_go;
    t_result                                  w_res;

    assign w_count_inc = r_count + LENGTH_BITS'(1);
    assign w_rem_dec   = r_extra_rem - 16'd1;
    assign w_count_ext = {{HeaderLengthWidth{1'b0}}, w_count_inc};

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_flags     = r_flags;
        n_extra_rem = r_extra_rem;
        n_extra_lo  = r_extra_lo;
        w_next      = PH_COMPLETE;
        w_go        = 1'b0;
        w_res       = '0;
        w_res.status = ST_OK;

        if (r_phase != PH_IDLE) begin
            if (r_count == {LENGTH_BITS{1'b1}}) begin
                w_res.valid  = 1'b1;
                w_res.status = ST_OVERFLOW;
            end else begin
                n_count = w_count_inc;
                case (r_phase)
                    PH_ID1: begin
                        if (i_step.data_byte != MagicFirst) begin
                            w_res.valid  = 1'b1;
                            w_res.status = ST_BAD_MAGIC;
                        end else begin
                            n_phase = PH_ID2;
                        end
                    end
                    PH_ID2: begin
                        if (i_step.data_byte != MagicSecond) begin
                            w_res.valid  = 1'b1;
                            w_res.status = ST_BAD_MAGIC;
                        end else begin
                            n_phase = PH_METHOD;
                        end
                    end
                    PH_METHOD: begin
                        if (i_step.data_byte != MethodDeflate) begin
                            w_res.valid  = 1'b1;
                            w_res.status = ST_BAD_METH;
                        end else begin
                            n_phase = PH_FLAGS;
                        end
                    end
                    PH_FLAGS: begin
                        if ((i_step.data_byte & ReservedMask) != 8'd0) begin
                            w_res.valid  = 1'b1;
                            w_res.status = ST_BAD_METH;
                        end else begin
                            n_flags = i_step.data_byte[4:0];
                            n_phase = PH_FIXED;
                        end
                    end
                    PH_FIXED: begin
                        if (w_count_inc >= LENGTH_BITS'(FixedBytes)) begin
                            w_next = next_section(r_flags, SEC_FIXED);
                            w_go   = 1'b1;
                        end
                    end
                    PH_XLEN_LO: begin
                        n_extra_lo = i_step.data_byte;
                        n_phase    = PH_XLEN_HI;
                    end
                    PH_XLEN_HI: begin
                        n_extra_rem = {i_step.data_byte, r_extra_lo};
                        if ({i_step.data_byte, r_extra_lo} == 16'd0) begin
                            w_next = next_section(r_flags, SEC_EXTRA);
                            w_go   = 1'b1;
                        end else begin
                            n_phase = PH_EXTRA;
                        end
                    end
                    PH_EXTRA: begin
                        n_extra_rem = w_rem_dec;
                        if (w_rem_dec == 16'd0) begin
                            w_next = next_section(r_flags, SEC_EXTRA);
                            w_go   = 1'b1;
                        end
                    end
                    PH_NAME: begin
                        if (i_step.data_byte == 8'd0) begin
                            w_next = next_section(r_flags, SEC_NAME);
                            w_go   = 1'b1;
                        end
                    end
                    PH_COMMENT: begin
                        if (i_step.data_byte == 8'd0) begin
                            w_next = next_section(r_flags, SEC_COMMENT);
                            w_go   = 1'b1;
                        end
                    end
                    PH_CRC_LO: begin
                        n_phase = PH_CRC_HI;
                    end
                    PH_CRC_HI: begin
                        w_next = PH_COMPLETE;
                        w_go   = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase

                if (w_go) begin
                    if (w_next == PH_COMPLETE) begin
                        w_res.valid         = 1'b1;
                        w_res.status        = ST_OK;
                        w_res.header_length = w_count_ext[HeaderLengthWidth-1:0];
                    end else begin
                        n_phase = w_next;
                    end
                end
            end
            if (w_res.valid) begin
                n_phase = PH_IDLE;
            end
        end

        // The last byte closes the buffer: a header still open is truncated,
        // and the whole parse state rearms for the next buffer.
        if (i_step.last_byte) begin
            if (n_phase != PH_IDLE) begin
                w_res.valid         = 1'b1;
                w_res.status        = ST_TRUNC;
                w_res.header_length = '0;
            end
            n_phase     = PH_ID1;
            n_count     = '0;
            n_flags     = '0;
            n_extra_rem = '0;
            n_extra_lo  = '0;
        end

        o_res       = w_res;
        o_res.valid = w_res.valid & i_step.valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ID1;
            r_count     <= '0;
            r_flags     <= '0;
            r_extra_rem <= '0;
            r_extra_lo  <= '0;
        end else if (i_step.valid) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_flags     <= n_flags;
            r_extra_rem <= n_extra_rem;
            r_extra_lo  <= n_extra_lo;
        end
    end

    // While skipping the extra field at least one byte is always left.
    a_extra_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_EXTRA |-> r_extra_rem != 16'd0)
        else $error("extra field phase with nothing left to skip");

    // Before the flag byte has been taken the stored flags are still clear.
    a_flags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ID1 || r_phase == PH_ID2 || r_phase == PH_METHOD ||
         r_phase == PH_FLAGS) |-> r_flags == 5'd0)
        else $error("flags held before the flag byte");

    // After a result the parser either idles or has rearmed on a last byte.
    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |=> (r_phase == PH_IDLE || r_phase == PH_ID1))
        else $error("parser still active after giving a result");

endmodule

`default_nettype wire

// ----- rtl/gzip_header_parser_unit.sv -----
// Top level of the gzip header parser: input word register, parse core and
// result register. Depends on gzp_pkg, gzp_byte_if, gzp_result_if, gzp_parse_core.
//
// Use: buffer bytes arrive on i_byte, one byte per word, in order, with
// last_byte set on the final byte of each buffer. The block parses one
// gzip member header per buffer and gives at most one word on o_result:
// the status (ok, bad magic, bad method or reserved flag, truncated, length
// overflow) and the header length, which is zero on any failure. The word
// appears as soon as the header is complete or has failed; the bytes that
// follow up to the last mark are swallowed without a result, and the block
// then rearms for the next buffer. A buffer that ends inside the header
// gives a truncated status on its last byte.
// Throughput is one byte per cycle while results are taken. A byte is
// registered on acceptance and is parsed once the output register has room,
// and the result it causes is registered there before it shows on o_result.
// Reset (synchronous, active low) empties both registers and sets the
// parser to expect the first magic byte of a fresh buffer.
// When the receiver stalls, the result stays in the output register; the
// next byte is still taken into the input register and waits there, and
// i_byte.ready drops only while both registers are held.
`default_nettype none

module gzip_header_parser_unit #(
    parameter int unsigned LENGTH_BITS = gzp_pkg::LengthBitsDefault
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    gzp_byte_if.sink     i_byte,
    gzp_result_if.source o_result
);
    import gzp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic                         r_out_valid;
    logic [2:0]                   r_out_status;
    logic [HeaderLengthWidth-1:0] r_out_length;

    logic    w_advance;
    t_step   w_step;
    t_result w_res;

    // The held byte is parsed once there is room for a possible result.
    assign w_advance    = r_in_valid & (~r_out_valid | o_result.ready);
    assign i_byte.ready = ~r_in_valid | w_advance;

    assign w_step.valid     = w_advance;
    assign w_step.data_byte = r_in_byte;
    assign w_step.last_byte = r_in_last;

    gzp_parse_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_out_status <= w_res.status;
            r_out_length <= w_res.header_length;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.status        = r_out_status;
    assign o_result.header_length = r_out_length;

    // A byte that cannot be parsed yet stays in the input register unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("held input word lost or changed");

    // A complete header is never shorter than the fixed part.
    a_ok_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == ST_OK |-> r_out_length >= HeaderLengthWidth'(FixedBytes))
        else $error("ok result with a header shorter than the fixed part");

    // Every failure carries a zero length.
    a_fail_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != ST_OK |-> r_out_length == '0)
        else $error("failure result with a nonzero length");

    // No new result may be produced while an untaken one is still held.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_result.ready |-> !w_res.valid)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ----- bench/gzip_header_checker.sv -----
// Checker for the gzip header parser: follows the byte and result channels,
// predicts each result word and compares it field by field.
// Depends on gzp_pkg, gzp_byte_if and gzp_result_if.
`default_nettype none

module gzip_header_checker #(
    parameter int unsigned LENGTH_BITS = gzp_pkg::LengthBitsDefault
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    gzp_byte_if         byte_ch,
    gzp_result_if       res_ch,
    output int unsigned o_failures,
    output int unsigned o_outstanding,
    output int unsigned o_verdicts
);
    timeunit 1ns;
    timeprecision 1ps;

    import gzp_pkg::*;

    typedef struct packed {
        logic [2:0]                   status;
        logic [HeaderLengthWidth-1:0] header_length;
    } t_verdict;

    t_verdict expected_verdicts[$];
    t_verdict oldest_verdict;

    // Parser state as the predictor sees it.
    logic [3:0]             phase;
    logic [LENGTH_BITS-1:0] parsed_count;
    logic [4:0]             hdr_flags;
    logic [15:0]            extra_left;
    logic [7:0]             extra_lo;

    task automatic rearm_parser();
        phase        = PH_ID1;
        parsed_count = '0;
        hdr_flags    = '0;
        extra_left   = '0;
        extra_lo     = '0;
    endtask

    // Optional section that follows the given finished section, or complete.
    function automatic logic [3:0] section_after(input logic [2:0] done);
        if (done < SEC_EXTRA && hdr_flags[FlagExtraBit]) return PH_XLEN_LO;
        if (done < SEC_NAME && hdr_flags[FlagNameBit]) return PH_NAME;
        if (done < SEC_COMMENT && hdr_flags[FlagCommentBit]) return PH_COMMENT;
        if (hdr_flags[FlagHcrcBit]) return PH_CRC_LO;
        return PH_COMPLETE;
    endfunction

    task automatic parse_header_byte(input logic [7:0] b, input logic last);
        logic [2:0]                   st;
        logic [HeaderLengthWidth-1:0] len;
        logic [3:0]                   nxt;
        bit                           hit;
        bit                           go;
        st  = ST_OK;
        len = '0;
        nxt = PH_IDLE;
        hit = 1'b0;
        go  = 1'b0;
        if (phase != PH_IDLE) begin
            if (&parsed_count) begin
                st  = ST_OVERFLOW;
                hit = 1'b1;
            end else begin
                parsed_count = parsed_count + 1'b1;
                case (phase)
                    PH_ID1: begin
                        if (b != MagicFirst) begin
                            st  = ST_BAD_MAGIC;
                            hit = 1'b1;
                        end else begin
                            phase = PH_ID2;
                        end
                    end
                    PH_ID2: begin
                        if (b != MagicSecond) begin
                            st  = ST_BAD_MAGIC;
                            hit = 1'b1;
                        end else begin
                            phase = PH_METHOD;
                        end
                    end
                    PH_METHOD: begin
                        if (b != MethodDeflate) begin
                            st  = ST_BAD_METH;
                            hit = 1'b1;
                        end else begin
                            phase = PH_FLAGS;
                        end
                    end
                    PH_FLAGS: begin
                        if ((b & ReservedMask) != 8'd0) begin
                            st  = ST_BAD_METH;
                            hit = 1'b1;
                        end else begin
                            hdr_flags = b[4:0];
                            phase     = PH_FIXED;
                        end
                    end
                    PH_FIXED: begin
                        if (parsed_count >= FixedBytes) begin
                            nxt = section_after(SEC_FIXED);
                            go  = 1'b1;
                        end
                    end
                    PH_XLEN_LO: begin
                        extra_lo = b;
                        phase    = PH_XLEN_HI;
                    end
                    PH_XLEN_HI: begin
                        extra_left = {b, extra_lo};
                        if (extra_left == 16'd0) begin
                            nxt = section_after(SEC_EXTRA);
                            go  = 1'b1;
                        end else begin
                            phase = PH_EXTRA;
                        end
                    end
                    PH_EXTRA: begin
                        extra_left = extra_left - 16'd1;
                        if (extra_left == 16'd0) begin
                            nxt = section_after(SEC_EXTRA);
                            go  = 1'b1;
                        end
                    end
                    PH_NAME: begin
                        if (b == 8'd0) begin
                            nxt = section_after(SEC_NAME);
                            go  = 1'b1;
                        end
                    end
                    PH_COMMENT: begin
                        if (b == 8'd0) begin
                            nxt = section_after(SEC_COMMENT);
                            go  = 1'b1;
                        end
                    end
                    PH_CRC_LO: begin
                        phase = PH_CRC_HI;
                    end
                    PH_CRC_HI: begin
                        nxt = PH_COMPLETE;
                        go  = 1'b1;
                    end
                    default: begin
                        phase = PH_IDLE;
                    end
                endcase
                if (go) begin
                    if (nxt == PH_COMPLETE) begin
                        st  = ST_OK;
                        len = HeaderLengthWidth'(parsed_count);
                        hit = 1'b1;
                    end else begin
                        phase = nxt;
                    end
                end
            end
            if (hit) phase = PH_IDLE;
        end
        if (last) begin
            // A buffer that stops while the header is still open is truncated.
            if (phase != PH_IDLE) begin
                st  = ST_TRUNC;
                len = '0;
                hit = 1'b1;
            end
            rearm_parser();
        end
        if (hit) expected_verdicts.push_back('{status: st, header_length: len});
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rearm_parser();
            expected_verdicts.delete();
            o_failures <= 0;
            o_verdicts <= 0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                parse_header_byte(byte_ch.data_byte, byte_ch.last_byte);
            end
            if (res_ch.valid && res_ch.ready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: result word with nothing expected: %s %0d length %0d",
                             $time, "expected none, got status",
                             res_ch.status, res_ch.header_length);
                    o_failures <= o_failures + 1;
                end else begin
                    oldest_verdict = expected_verdicts.pop_front();
                    o_verdicts <= o_verdicts + 1;
                    if (res_ch.status !== oldest_verdict.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, oldest_verdict.status, res_ch.status);
                        o_failures <= o_failures + 1;
                    end else if (res_ch.header_length !== oldest_verdict.header_length) begin
                        $display("%0t: header_length expected %0d, got %0d",
                                 $time, oldest_verdict.header_length, res_ch.header_length);
                        o_failures <= o_failures + 1;
                    end
                end
            end
        end
        o_outstanding <= expected_verdicts.size();
    end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Top of the gzip header parser bench: clock, reset, byte and result stimulus
// with random idling, and the verdict. Depends on gzp_pkg, both channel
// interfaces, gzip_header_parser_unit and gzip_header_checker.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gzp_pkg::*;

    // The block runs with a length counter narrower than the result field, so
    // the header length reaches the result port zero-extended.
    localparam int unsigned LenBits     = 17;
    localparam int unsigned RandomBytes = 450;

    logic i_clk;
    logic i_rst_n;

    gzp_byte_if   byte_ch ();
    gzp_result_if res_ch ();

    int unsigned failures;
    int unsigned outstanding;
    int unsigned verdicts;

    // Stimulus bookkeeping and idling controls shared by the two sides.
    logic [7:0]  byte_buf[$];
    int unsigned buffers_sent;
    int unsigned bytes_sent;
    bit          tx_quiet;
    bit          rx_quiet;
    int unsigned rx_hold_req;

    gzip_header_parser_unit #(
        .LENGTH_BITS(LenBits)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_result(res_ch)
    );

    gzip_header_checker #(
        .LENGTH_BITS(LenBits)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .byte_ch      (byte_ch),
        .res_ch       (res_ch),
        .o_failures   (failures),
        .o_outstanding(outstanding),
        .o_verdicts   (verdicts)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run: several times the slowest legal run, in which
    // every byte and every result word waits the longest idle time.
    initial begin
        #1ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offers one word on the byte channel after a random gap and returns at
    // the edge at which it is taken. Valid is left high, so a following word
    // with no gap goes out back to back.
    task automatic send_byte(input logic [7:0] d, input logic l);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= d;
        byte_ch.last_byte <= l;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
    endtask

    // Sends the buffer held in byte_buf, with the last mark on its final word.
    task automatic send_buffer();
        for (int i = 0; i < byte_buf.size(); i++) begin
            send_byte(byte_buf[i], i == byte_buf.size() - 1);
        end
        buffers_sent++;
        bytes_sent += byte_buf.size();
    endtask

    // Appends a well-formed member header to byte_buf. Name and comment get
    // the given number of non-zero bytes before their terminator.
    task automatic build_header(input logic [4:0] flg, input int unsigned xlen,
                                input int unsigned nlen, input int unsigned clen);
        byte_buf.push_back(MagicFirst);
        byte_buf.push_back(MagicSecond);
        byte_buf.push_back(MethodDeflate);
        byte_buf.push_back({3'b000, flg});
        repeat (FixedBytes - 4) byte_buf.push_back(8'($urandom));
        if (flg[FlagExtraBit]) begin
            byte_buf.push_back(xlen[7:0]);
            byte_buf.push_back(xlen[15:8]);
            repeat (xlen) byte_buf.push_back(8'($urandom));
        end
        if (flg[FlagNameBit]) begin
            repeat (nlen) byte_buf.push_back(8'($urandom_range(1, 255)));
            byte_buf.push_back(8'h00);
        end
        if (flg[FlagCommentBit]) begin
            repeat (clen) byte_buf.push_back(8'($urandom_range(1, 255)));
            byte_buf.push_back(8'h00);
        end
        if (flg[FlagHcrcBit]) begin
            byte_buf.push_back(8'($urandom));
            byte_buf.push_back(8'($urandom));
        end
    endtask

    // Result side: a random stall before each word, or a long hold-off when
    // the stimulus asks for one so that the block backs up into its input.
    initial begin
        int unsigned stall;
        forever begin
            if (rx_hold_req != 0) begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                stall = rx_quiet ? 0 : $urandom_range(0, 15);
            end
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
        end
    end

    // Byte side: directed buffers, a back-pressure burst and random buffers.
    initial begin
        int unsigned kind;
        int unsigned hdr_len;
        int unsigned keep;
        logic [4:0]  flg;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        byte_ch.last_byte <= 1'b0;
        i_rst_n           <= 1'b0;
        buffers_sent = 0;
        bytes_sent   = 0;
        tx_quiet     = 1'b0;
        rx_quiet     = 1'b0;
        rx_hold_req  = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Bad first magic byte on a one-word buffer.
        byte_buf = '{8'h00};
        send_buffer();
        // Bad second magic byte, all ones.
        byte_buf = '{MagicFirst, 8'hFF};
        send_buffer();
        // Wrong method on the last word: only the failure is reported.
        byte_buf = '{MagicFirst, MagicSecond, 8'h07};
        send_buffer();
        // Reserved flag bit set, again on the last word.
        byte_buf = '{MagicFirst, MagicSecond, MethodDeflate, 8'h20};
        send_buffer();
        // Buffer that stops right after the first magic byte.
        byte_buf = '{MagicFirst};
        send_buffer();
        // Extra field of length zero: just its two length bytes.
        byte_buf.delete();
        build_header(5'(1 << FlagExtraBit), 0, 0, 0);
        send_buffer();

        // Back-pressure: the receiver holds off for a long stretch while
        // one-word buffers with a bad magic byte keep arriving back to back,
        // so both registers of the block fill and its input stalls.
        rx_hold_req = 200;
        tx_quiet    = 1'b1;
        repeat (12) begin
            byte_buf = '{8'($urandom_range(0, 8'h1E))};
            send_buffer();
        end
        tx_quiet = 1'b0;

        // Random part: mostly well-formed headers with random content and
        // random optional sections, some truncated, the rest broken headers
        // and short noise buffers.
        while (bytes_sent < RandomBytes) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            byte_buf.delete();
            kind = $urandom_range(0, 9);
            if (kind <= 7) begin
                flg = 5'($urandom);
                build_header(flg, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6),
                             $urandom_range(0, 5), $urandom_range(0, 5));
                hdr_len = byte_buf.size();
                repeat ($urandom_range(0, 3)) byte_buf.push_back(8'($urandom));
                if (kind == 7) begin
                    // Broken header: one of the checked bytes replaced.
                    byte_buf[$urandom_range(0, 3)] = 8'($urandom);
                end else if ($urandom_range(0, 4) == 0) begin
                    keep     = $urandom_range(1, hdr_len - 1);
                    byte_buf = byte_buf[0:keep-1];
                end
            end else begin
                repeat ($urandom_range(1, 6)) byte_buf.push_back(8'($urandom));
                if ($urandom_range(0, 1) == 0) byte_buf[0] = MagicFirst;
            end
            send_buffer();
        end
        byte_ch.valid <= 1'b0;

        // Drain: wait for every predicted word, then long enough for a stray
        // word to show up even behind the longest receiver stall.
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Ran %0d buffers, %0d bytes in all: good, broken, cut-short and noise headers.",
                 buffers_sent, bytes_sent);
        $display("Compared %0d result words against the prediction.", verdicts);
        if (failures == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
